// ===== sv/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// slcd_pkg : shared types and constants of the sync/length/checksum deframer
// Frame parse phases, event codes, configuration register indexes.
// ----------------------------------------------------------------------------
package slcd_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_ID   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] PREAMBLE_RST = 8'hFA;
    localparam logic [BYTE_W-1:0] BUS_ID_RST   = 8'hFF;

    // Length byte that announces a two-byte extended length
    localparam logic [BYTE_W-1:0] EXT_MARK = 8'hFF;

    // Parse phases
    typedef enum logic [2:0] {
        PH_PREAMBLE = 3'd0,
        PH_BUSID    = 3'd1,
        PH_MSGID    = 3'd2,
        PH_LEN      = 3'd3,
        PH_EXTHI    = 3'd4,
        PH_EXTLO    = 3'd5,
        PH_PAYLOAD  = 3'd6,
        PH_CHECK    = 3'd7
    } t_phase;

    // Event codes
    typedef enum logic [KIND_W-1:0] {
        EV_MSG_ID    = 3'd0,
        EV_LENGTH    = 3'd1,
        EV_PAYLOAD   = 3'd2,
        EV_FRAME_OK  = 3'd3,
        EV_FRAME_BAD = 3'd4
    } t_event_kind;

    // One event from the parser to the output register
    typedef struct packed {
        logic                     valid;
        t_event_kind              kind;
        logic [VALUE_W-1:0]       value;
    } t_event;

endpackage

// ===== sv/slcd_rx_if.sv =====
// ----------------------------------------------------------------------------
// slcd_rx_if : received byte channel
// valid/ready handshake carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface slcd_rx_if;
    logic                         valid;
    logic                         ready;
    logic [slcd_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/slcd_evt_if.sv =====
// ----------------------------------------------------------------------------
// slcd_evt_if : deframer event channel
// valid/ready handshake carrying one event kind and value per beat.
// ----------------------------------------------------------------------------
interface slcd_evt_if;
    logic                          valid;
    logic                          ready;
    logic [slcd_pkg::KIND_W-1:0]   event_kind;
    logic [slcd_pkg::VALUE_W-1:0]  event_value;

    modport source (output valid, output event_kind, output event_value, input ready);
    modport sink   (input valid, input event_kind, input event_value, output ready);
endinterface

// ===== sv/slcd_parser.sv =====
// ----------------------------------------------------------------------------
// slcd_parser : frame parse state and configuration registers
// Updates the parse state on every accepted byte and forms the event, if any, for it.
// ----------------------------------------------------------------------------
module slcd_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [slcd_pkg::BYTE_W-1:0]       i_byte,
    input  logic                              i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slcd_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output slcd_pkg::t_event                  o_evt
);

    slcd_pkg::t_phase                 r_phase,   n_phase;
    logic [slcd_pkg::VALUE_W-1:0]     r_len,     n_len;
    logic [slcd_pkg::VALUE_W-1:0]     r_seen,    n_seen;
    logic [slcd_pkg::BYTE_W-1:0]      r_sum,     n_sum;
    logic [slcd_pkg::BYTE_W-1:0]      r_len_hi,  n_len_hi;
    logic [slcd_pkg::BYTE_W-1:0]      r_preamble;
    logic [slcd_pkg::BYTE_W-1:0]      r_bus_id;

    logic [slcd_pkg::BYTE_W-1:0]      sum_add;
    logic [slcd_pkg::VALUE_W-1:0]     seen_inc;
    logic [slcd_pkg::VALUE_W-1:0]     new_len;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble <= slcd_pkg::PREAMBLE_RST;
            r_bus_id   <= slcd_pkg::BUS_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                slcd_pkg::CFG_PREAMBLE: r_preamble <= i_cfg_data;
                slcd_pkg::CFG_BUS_ID:   r_bus_id   <= i_cfg_data;
                default:                r_preamble <= r_preamble;
            endcase
        end
    end

    assign sum_add  = r_sum + i_byte;
    assign seen_inc = r_seen + slcd_pkg::VALUE_W'(1);

    // Next state and event for the byte on the input
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_seen    = r_seen;
        n_sum     = sum_add;
        n_len_hi  = r_len_hi;
        new_len   = {{(slcd_pkg::VALUE_W-slcd_pkg::BYTE_W){1'b0}}, i_byte};
        o_evt     = '{valid: 1'b0, kind: slcd_pkg::EV_MSG_ID, value: '0};

        unique case (r_phase)
            slcd_pkg::PH_PREAMBLE: begin
                n_sum = r_sum;
                if (i_byte == r_preamble) begin
                    n_phase = slcd_pkg::PH_BUSID;
                    n_sum   = '0;
                    n_len   = '0;
                    n_seen  = '0;
                end
            end
            slcd_pkg::PH_BUSID: begin
                n_phase = (i_byte == r_bus_id) ? slcd_pkg::PH_MSGID : slcd_pkg::PH_PREAMBLE;
            end
            slcd_pkg::PH_MSGID: begin
                n_phase     = slcd_pkg::PH_LEN;
                o_evt.valid = 1'b1;
                o_evt.kind  = slcd_pkg::EV_MSG_ID;
                o_evt.value = new_len;
            end
            slcd_pkg::PH_LEN: begin
                if (i_byte == slcd_pkg::EXT_MARK) begin
                    n_phase = slcd_pkg::PH_EXTHI;
                end else begin
                    n_len       = new_len;
                    n_seen      = '0;
                    n_phase     = (new_len == '0) ? slcd_pkg::PH_CHECK : slcd_pkg::PH_PAYLOAD;
                    o_evt.valid = 1'b1;
                    o_evt.kind  = slcd_pkg::EV_LENGTH;
                    o_evt.value = new_len;
                end
            end
            slcd_pkg::PH_EXTHI: begin
                n_len_hi = i_byte;
                n_phase  = slcd_pkg::PH_EXTLO;
            end
            slcd_pkg::PH_EXTLO: begin
                new_len     = {r_len_hi, i_byte};
                n_len       = new_len;
                n_seen      = '0;
                n_phase     = (new_len == '0) ? slcd_pkg::PH_CHECK : slcd_pkg::PH_PAYLOAD;
                o_evt.valid = 1'b1;
                o_evt.kind  = slcd_pkg::EV_LENGTH;
                o_evt.value = new_len;
            end
            slcd_pkg::PH_PAYLOAD: begin
                n_seen = seen_inc;
                if (seen_inc >= r_len) begin
                    n_phase = slcd_pkg::PH_CHECK;
                end
                o_evt.valid = 1'b1;
                o_evt.kind  = slcd_pkg::EV_PAYLOAD;
                o_evt.value = new_len;
            end
            slcd_pkg::PH_CHECK: begin
                n_phase     = slcd_pkg::PH_PREAMBLE;
                o_evt.valid = 1'b1;
                o_evt.kind  = (sum_add == '0) ? slcd_pkg::EV_FRAME_OK : slcd_pkg::EV_FRAME_BAD;
                o_evt.value = '0;
            end
            default: begin
                n_phase = slcd_pkg::PH_PREAMBLE;
            end
        endcase
    end

    // Parse state, updated only on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= slcd_pkg::PH_PREAMBLE;
            r_len    <= '0;
            r_seen   <= '0;
            r_sum    <= '0;
            r_len_hi <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_sum    <= n_sum;
            r_len_hi <= n_len_hi;
        end
    end

endmodule

// ===== sv/slcd_out_reg.sv =====
// ----------------------------------------------------------------------------
// slcd_out_reg : event output register
// Holds one event until taken; frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
module slcd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  slcd_pkg::t_event  i_evt,
    output logic              o_space,
    slcd_evt_if.source        o_evt
);

    logic                             r_valid;
    slcd_pkg::t_event_kind            r_kind;
    logic [slcd_pkg::VALUE_W-1:0]     r_value;

    // Room for a new event when empty or when the held one leaves now
    assign o_space = !r_valid || o_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_evt.valid;
        end else if (o_evt.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load && i_evt.valid) begin
            r_kind  <= i_evt.kind;
            r_value <= i_evt.value;
        end
    end

    assign o_evt.valid       = r_valid;
    assign o_evt.event_kind  = r_kind;
    assign o_evt.event_value = r_value;

endmodule

// ===== sv/sync_length_checksum_deframer_core.sv =====
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core : preamble/length/checksum frame parser
// An event is registered and appears on o_evt in the cycle after its byte beat is taken.
// Throughput: one byte per cycle; i_rx.ready stays high while the output
// register is empty or being read, so bytes stream back to back.
// Reset: synchronous, active low; waits for a preamble, registers to defaults.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    slcd_rx_if.sink                           i_rx,
    slcd_evt_if.source                        o_evt,
    input  logic                              i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slcd_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    logic              space;
    logic              accept;
    slcd_pkg::t_event  evt;

    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    // Parse state and event decode
    slcd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_rx.rx_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_evt      (evt)
    );

    // Result register
    slcd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_evt   (evt),
        .o_space (space),
        .o_evt   (o_evt)
    );

endmodule
